// ===== sv/knsq_pkg.sv =====
// Shared types and constants for the Kruskal norm-squared unit.
package knsq_pkg;

  localparam int CMD_W  = 2;
  localparam int IDX_W  = 4;
  localparam int VAL_W  = 32;
  localparam int OUT_W  = 63;
  localparam int RANK_W = 5;

  localparam logic [RANK_W-1:0] RANK_RESET = 5'd16;
  localparam logic signed [VAL_W-1:0] Q_ONE = 32'sh0001_0000;

  typedef enum logic [CMD_W-1:0] {
    CMD_GRAM   = 2'd0,
    CMD_WEIGHT = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_code_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic mul_write;
    logic weight_write;
    logic walk_issue;
    logic diag;
    logic acc_clear;
    logic sweep_write;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pipe_busy;
    logic gram_ok;
    logic weight_ok;
  } dp_status_t;

endpackage

// ===== sv/knsq_ifs.sv =====
// Valid/ready channel interfaces for input items and results.
interface knsq_in_if;
  import knsq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [IDX_W-1:0]        row;
  logic [IDX_W-1:0]        col;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output cmd, output row, output col, output value,
                  input ready);
  modport sink   (input valid, input cmd, input row, input col, input value,
                  output ready);
endinterface

interface knsq_out_if;
  import knsq_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] norm_squared;

  modport source (output valid, output norm_squared, input ready);
  modport sink   (input valid, input norm_squared, output ready);
endinterface

// ===== sv/knsq_ctrl.sv =====
// Controller: sequences Gram updates, the finish walk, drain and store clearing.
module knsq_ctrl #(
  parameter int MAX_RANK = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  input  logic [knsq_pkg::CMD_W-1:0]  item_cmd,
  output logic                        item_ready,
  input  logic                        out_ready,
  output logic                        out_valid,
  input  logic                        cfg_write,
  input  logic [knsq_pkg::RANK_W-1:0] cfg_data,
  input  knsq_pkg::dp_status_t        status,
  output knsq_pkg::ctrl_cmd_t         cmd,
  output logic [((MAX_RANK > 1) ? $clog2(MAX_RANK) : 1)-1:0] i_idx,
  output logic [((MAX_RANK > 1) ? $clog2(MAX_RANK) : 1)-1:0] j_idx,
  output logic [((MAX_RANK * MAX_RANK > 1) ? $clog2(MAX_RANK * MAX_RANK) : 1)-1:0] sweep_addr
);
  import knsq_pkg::*;

  localparam int DEPTH = MAX_RANK * MAX_RANK;
  localparam int RW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [RW-1:0] LAST_IDX  = RW'(MAX_RANK - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  typedef enum logic [2:0] {S_SWEEP, S_IDLE, S_MULW, S_WALK, S_DRAIN} state_t;

  state_t            state;
  logic [RANK_W-1:0] rank_in_use;
  logic [AW-1:0]     sweep_cnt;
  logic [RW-1:0]     last_idx;
  logic              accept;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign sweep_addr = sweep_cnt;

  // A rank of zero behaves as one; ranks beyond the store behave as the full size.
  always_comb begin
    if (rank_in_use == '0) begin
      last_idx = '0;
    end else if (int'(rank_in_use) > MAX_RANK) begin
      last_idx = LAST_IDX;
    end else begin
      last_idx = RW'(rank_in_use - 5'd1);
    end
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (item_cmd)
            CMD_GRAM:   cmd.capture      = status.gram_ok;
            CMD_WEIGHT: cmd.weight_write = status.weight_ok;
            CMD_FINISH: cmd.acc_clear    = 1'b1;
            default:    cmd = '0;
          endcase
        end
      end
      S_MULW:  cmd.mul_write = 1'b1;
      S_WALK: begin
        cmd.walk_issue = 1'b1;
        cmd.diag       = (i_idx == j_idx);
      end
      S_DRAIN: cmd.out_load = !status.pipe_busy && (!out_valid || out_ready);
      S_SWEEP: cmd.sweep_write = 1'b1;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      rank_in_use <= RANK_RESET;
      sweep_cnt   <= '0;
      out_valid   <= 1'b0;
      i_idx       <= '0;
      j_idx       <= '0;
    end else begin
      if (cfg_write) begin
        rank_in_use <= cfg_data;
      end

      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd.capture) begin
            state <= S_MULW;
          end else if (cmd.acc_clear) begin
            i_idx <= '0;
            j_idx <= '0;
            state <= S_WALK;
          end
        end
        S_MULW: state <= S_IDLE;
        S_WALK: begin
          // Upper triangle in row order, diagonal first in each row.
          if (j_idx == last_idx) begin
            if (i_idx == last_idx) begin
              state <= S_DRAIN;
            end else begin
              i_idx <= i_idx + 1'b1;
              j_idx <= i_idx + 1'b1;
            end
          end else begin
            j_idx <= j_idx + 1'b1;
          end
        end
        S_DRAIN: begin
          if (cmd.out_load) begin
            sweep_cnt <= '0;
            state     <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (sweep_cnt == LAST_ADDR) begin
            state <= S_IDLE;
          end else begin
            sweep_cnt <= sweep_cnt + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/knsq_datapath.sv =====
// Datapath: product and weight stores, multiply pipeline and saturating accumulator.
module knsq_datapath #(
  parameter int MAX_RANK = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  knsq_pkg::ctrl_cmd_t                cmd,
  output knsq_pkg::dp_status_t               status,
  input  logic [((MAX_RANK > 1) ? $clog2(MAX_RANK) : 1)-1:0] i_idx,
  input  logic [((MAX_RANK > 1) ? $clog2(MAX_RANK) : 1)-1:0] j_idx,
  input  logic [((MAX_RANK * MAX_RANK > 1) ? $clog2(MAX_RANK * MAX_RANK) : 1)-1:0] sweep_addr,
  input  logic [knsq_pkg::IDX_W-1:0]         row,
  input  logic [knsq_pkg::IDX_W-1:0]         col,
  input  logic signed [knsq_pkg::VAL_W-1:0]  value,
  output logic [knsq_pkg::OUT_W-1:0]         norm_squared
);
  import knsq_pkg::*;

  localparam int DEPTH = MAX_RANK * MAX_RANK;
  localparam int RW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Q16.16 product post-processing: floor shift by 16, saturate to 32 bits.
  function automatic logic signed [31:0] q_round(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> 16;
    if (s[63:31] == '0 || s[63:31] == '1) begin
      q_round = s[31:0];
    end else begin
      q_round = s[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  endfunction

  logic signed [VAL_W-1:0] hmem [DEPTH];
  logic signed [VAL_W-1:0] wmem [MAX_RANK];

  logic [AW-1:0]           in_addr;
  logic [AW-1:0]           walk_addr;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           hold_addr;
  logic signed [VAL_W-1:0] hold_val;
  logic signed [VAL_W-1:0] h_rd;
  logic signed [VAL_W-1:0] w_i;
  logic signed [VAL_W-1:0] w_j;

  logic v1, v2, v3, v4, v5;
  logic d1, d2, d3, d4;
  logic signed [63:0]      prod1;
  logic signed [VAL_W-1:0] lj2, lj3;
  logic signed [VAL_W-1:0] hq;
  logic signed [63:0]      prod2;
  logic signed [63:0]      term;
  logic signed [63:0]      acc;
  logic signed [VAL_W-1:0] tq;
  logic [64:0]             sum;

  assign in_addr   = AW'(int'(row) * MAX_RANK + int'(col));
  assign walk_addr = AW'(int'(i_idx) * MAX_RANK + int'(j_idx));
  assign rd_addr   = cmd.walk_issue ? walk_addr : in_addr;

  assign status.gram_ok   = (int'(row) < MAX_RANK) && (int'(col) < MAX_RANK);
  assign status.weight_ok = (int'(row) < MAX_RANK);
  assign status.pipe_busy = v1 || v2 || v3 || v4 || v5;

  // Product store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.sweep_write) begin
      hmem[sweep_addr] <= Q_ONE;
    end else if (cmd.mul_write) begin
      hmem[hold_addr] <= q_round(64'(h_rd) * 64'(hold_val));
    end
    h_rd <= hmem[rd_addr];
  end

  // Weight store: one write and two registered reads per cycle.
  always_ff @(posedge clk) begin
    if (cmd.weight_write) begin
      wmem[RW'(row)] <= value;
    end
    w_i <= wmem[i_idx];
    w_j <= wmem[j_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hold_addr <= in_addr;
      hold_val  <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= cmd.walk_issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  assign tq  = q_round(prod2);
  assign sum = {acc[63], acc} + {term[63], term};

  always_ff @(posedge clk) begin
    d1    <= cmd.diag;
    prod1 <= h_rd * w_i;
    lj2   <= w_j;
    d2    <= d1;
    hq    <= q_round(prod1);
    lj3   <= lj2;
    d3    <= d2;
    prod2 <= hq * lj3;
    d4    <= d3;
    // Off-diagonal terms count twice for the lower triangle.
    term  <= d4 ? {{32{tq[31]}}, tq} : {{31{tq[31]}}, tq, 1'b0};
    if (cmd.acc_clear) begin
      acc <= '0;
    end else if (v5) begin
      if (sum[64] != sum[63]) begin
        acc <= sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
        acc <= sum[63:0];
      end
    end
    if (cmd.out_load) begin
      if (!acc[63]) begin
        norm_squared <= acc[62:0];
      end else if (acc[62:0] == '0) begin
        norm_squared <= '1;
      end else begin
        norm_squared <= OUT_W'(-acc);
      end
    end
  end

endmodule

// ===== sv/kruskal_norm_squared_unit.sv =====
// Top level of the Kruskal tensor squared-norm unit.
// A Gram element item is read, then multiplied and written back into the product
// store through its one write port; weight items and unused commands need no extra state.
// A finish item walks r*(r+1)/2 upper-triangle entries, one per cycle, where r is
// rank_in_use clamped to 1..MAX_RANK, then drains the 5-stage multiply pipeline,
// loads the result register, and runs a clearing pass that rewrites every one of
// the MAX_RANK*MAX_RANK product entries to one, one per cycle. The same clearing
// pass runs after reset. Items are not accepted during the Gram write-back, the
// walk, drain and clearing; configuration writes are taken at any time. The
// result waits in an output register, so Gram and weight items continue meanwhile.
module kruskal_norm_squared_unit #(
  parameter int MAX_RANK = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  knsq_in_if.sink                     items,
  knsq_out_if.source                  results,
  input  logic                        cfg_write,
  input  logic [knsq_pkg::RANK_W-1:0] cfg_data
);
  import knsq_pkg::*;

  localparam int DEPTH = MAX_RANK * MAX_RANK;
  localparam int RW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ctrl_cmd_t     cmd;
  dp_status_t    status;
  logic [RW-1:0] i_idx;
  logic [RW-1:0] j_idx;
  logic [AW-1:0] sweep_addr;

  knsq_ctrl #(.MAX_RANK(MAX_RANK)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (items.valid),
    .item_cmd   (items.cmd),
    .item_ready (items.ready),
    .out_ready  (results.ready),
    .out_valid  (results.valid),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .status     (status),
    .cmd        (cmd),
    .i_idx      (i_idx),
    .j_idx      (j_idx),
    .sweep_addr (sweep_addr)
  );

  knsq_datapath #(.MAX_RANK(MAX_RANK)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .i_idx        (i_idx),
    .j_idx        (j_idx),
    .sweep_addr   (sweep_addr),
    .row          (items.row),
    .col          (items.col),
    .value        (items.value),
    .norm_squared (results.norm_squared)
  );

`ifndef ASSERT_OFF
  // No new item may enter while finish terms are still in flight.
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    items.ready |-> !status.pipe_busy)
    else $error("item accepted while multiply pipeline busy");

  // A finish item locks out further items on the next cycle.
  a_finish_locks: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready && items.cmd == CMD_FINISH) |=> !items.ready)
    else $error("finish item did not start the walk");

  // A new result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!results.valid || results.ready))
    else $error("result register overwritten");

  // Clearing and Gram write-back never compete for the store write port.
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep_write |-> !cmd.mul_write && !items.ready)
    else $error("product store write conflict");
`endif

endmodule
